@@ design/bolst_pkg.sv @@
// Shared types and codes for the bounded ordered list store.
// Holds the transfer payload structs, operation codes and cell and pool controls.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bolst_pkg;

   localparam int ENTRIES_DEFAULT = 16;

   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_GET    = 3'd1;
   localparam logic [2:0] OP_SEARCH = 3'd2;
   localparam logic [2:0] OP_REMOVE = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
      logic [3:0]         position;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic signed [31:0] value_out;
      logic [3:0]         slot;
      logic [4:0]         removed_count;
      logic               overwrote;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic scan;
      logic release_slot;
   } pool_ctrl_type;

endpackage

`default_nettype wire

@@ design/bolst_cell.sv @@
// One list cell: holds the value and slot number of one list position.
// Takes its neighbor's content on a shift, or the load data when selected.
// Depends on bolst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bolst_cell #(
   parameter int ENTRIES = bolst_pkg::ENTRIES_DEFAULT,
   parameter int INDEX   = 0
) (
   input  wire logic                          clock,
   input  wire bolst_pkg::cell_ctrl_type      ctrl,
   input  wire logic [$clog2(ENTRIES)-1:0]    ins_idx,
   input  wire logic signed [31:0]            load_value,
   input  wire logic [$clog2(ENTRIES)-1:0]    load_slot,
   input  wire logic signed [31:0]            next_value,
   input  wire logic [$clog2(ENTRIES)-1:0]    next_slot,
   output logic signed [31:0]                 value,
   output logic [$clog2(ENTRIES)-1:0]         slot
);
   import bolst_pkg::*;

   localparam int SLOT_W = $clog2(ENTRIES);

   logic signed [31:0] value_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic               sel;

   assign sel = ctrl.load && (ins_idx == SLOT_W'(INDEX));

   always_ff @(posedge clock) begin
      if (sel) begin
         value_ff <= load_value;
         slot_ff  <= load_slot;
      end else if (ctrl.shift) begin
         value_ff <= next_value;
         slot_ff  <= next_slot;
      end
   end

   assign value = value_ff;
   assign slot  = slot_ff;

endmodule

`default_nettype wire

@@ design/bolst_free_pool.sv @@
// Free-slot marks of the store and the scan for the lowest free slot.
// Scans one slot per cycle; a hit takes the slot, a release frees one.
// Depends on bolst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bolst_free_pool #(
   parameter int ENTRIES = bolst_pkg::ENTRIES_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bolst_pkg::pool_ctrl_type      ctrl,
   input  wire logic [$clog2(ENTRIES)-1:0]    release_idx,
   output logic                               hit,
   output logic [$clog2(ENTRIES)-1:0]         hit_slot
);
   import bolst_pkg::*;

   localparam int SLOT_W = $clog2(ENTRIES);

   logic [ENTRIES-1:0] free_ff;
   logic [SLOT_W-1:0]  scan_idx_ff;

   assign hit      = ctrl.scan && free_ff[scan_idx_ff];
   assign hit_slot = scan_idx_ff;

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         free_ff     <= '1;
         scan_idx_ff <= '0;
      end else begin
         if (ctrl.release_slot) begin
            free_ff[release_idx] <= 1'b1;
         end
         if (hit) begin
            free_ff[scan_idx_ff] <= 1'b0;
         end
         if (ctrl.scan && !hit) begin
            scan_idx_ff <= scan_idx_ff + SLOT_W'(1);
         end else begin
            scan_idx_ff <= '0;
         end
      end
   end

endmodule

`default_nettype wire

@@ design/bolst_store.sv @@
// Bounded ordered list store top level: controller, chain of list cells, free pool.
// Depends on bolst_pkg, bolst_cell and bolst_free_pool.
// Add: scans the pool from slot 0 up to the lowest free slot; when full, overwrites the oldest entry.
// Get, search, remove: rotate the list through the head cell, one entry per step.
// Clear and other ops go straight to the finish state. One item at a time; result register frees input.
// Reset: synchronous; empties the list and marks every slot free.
`timescale 1ns / 1ps
`default_nettype none

module bounded_ordered_list_store #(
   parameter int ENTRIES = bolst_pkg::ENTRIES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire bolst_pkg::req_type req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output bolst_pkg::rsp_type      rsp_data
);
   import bolst_pkg::*;

   localparam int SLOT_W = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = SLOT_W + 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_OVER,
      ST_ROTATE,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   req_type           req_ff;
   rsp_type           res_ff;
   rsp_type           rsp_data_ff;
   logic              rsp_valid_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [SLOT_W-1:0] step_ff;
   logic [CNT_W-1:0]  rm_ff;
   logic [CNT_W-1:0]  rm_in;

   cell_ctrl_type      cell_ctrl;
   logic [SLOT_W-1:0]  ins_idx;
   logic signed [31:0] load_value;
   logic [SLOT_W-1:0]  load_slot;
   logic signed [31:0] cell_value [ENTRIES];
   logic [SLOT_W-1:0]  cell_slot [ENTRIES];

   pool_ctrl_type     pool_ctrl;
   logic              pool_hit;
   logic [SLOT_W-1:0] pool_hit_slot;

   logic head_match;
   logic drop;
   logic last_step;
   logic req_xfer;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign head_match = (cell_value[0] == req_ff.value);
   assign drop       = (req_ff.op == OP_REMOVE) && head_match;
   assign last_step  = (CNT_W'(step_ff) == count_ff - CNT_W'(1));
   assign rm_in      = rm_ff + CNT_W'(drop);

   always_comb begin
      cell_ctrl  = '0;
      ins_idx    = '0;
      load_value = req_ff.value;
      load_slot  = pool_hit_slot;
      unique case (state_ff)
         ST_SCAN: begin
            cell_ctrl.load = pool_hit;
            ins_idx        = SLOT_W'(count_ff);
         end
         ST_OVER: begin
            cell_ctrl.shift = 1'b1;
            cell_ctrl.load  = 1'b1;
            ins_idx         = SLOT_W'(ENTRIES - 1);
            load_slot       = cell_slot[0];
         end
         ST_ROTATE: begin
            cell_ctrl.shift = 1'b1;
            cell_ctrl.load  = !drop;
            ins_idx         = SLOT_W'(count_ff - CNT_W'(1) - rm_ff);
            load_value      = cell_value[0];
            load_slot       = cell_slot[0];
         end
         default: begin
            cell_ctrl = '0;
         end
      endcase
   end

   always_comb begin
      pool_ctrl.clear        = req_xfer && (req_data.op == OP_CLEAR);
      pool_ctrl.scan         = (state_ff == ST_SCAN);
      pool_ctrl.release_slot = (state_ff == ST_ROTATE) && drop;
   end

   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      logic signed [31:0] nb_value;
      logic [SLOT_W-1:0]  nb_slot;
      if (k == ENTRIES - 1) begin : g_last
         assign nb_value = load_value;
         assign nb_slot  = load_slot;
      end else begin : g_mid
         assign nb_value = cell_value[k + 1];
         assign nb_slot  = cell_slot[k + 1];
      end
      bolst_cell #(
         .ENTRIES (ENTRIES),
         .INDEX   (k)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .ins_idx    (ins_idx),
         .load_value (load_value),
         .load_slot  (load_slot),
         .next_value (nb_value),
         .next_slot  (nb_slot),
         .value      (cell_value[k]),
         .slot       (cell_slot[k])
      );
   end

   bolst_free_pool #(
      .ENTRIES (ENTRIES)
   ) u_pool (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (pool_ctrl),
      .release_idx (cell_slot[0]),
      .hit         (pool_hit),
      .hit_slot    (pool_hit_slot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff  <= req_data;
                  res_ff  <= '0;
                  step_ff <= '0;
                  rm_ff   <= '0;
                  unique case (req_data.op) inside
                     OP_ADD: begin
                        state_ff <= (count_ff == CNT_W'(ENTRIES)) ? ST_OVER : ST_SCAN;
                     end
                     OP_GET, OP_SEARCH, OP_REMOVE: begin
                        state_ff <= (count_ff == '0) ? ST_FINISH : ST_ROTATE;
                     end
                     OP_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= ST_FINISH;
                     end
                     default: begin
                        state_ff <= ST_FINISH;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (pool_hit) begin
                  count_ff    <= count_ff + CNT_W'(1);
                  res_ff.ok   <= 1'b1;
                  res_ff.slot <= 4'(pool_hit_slot);
                  state_ff    <= ST_FINISH;
               end
            end
            ST_OVER: begin
               res_ff.ok        <= 1'b1;
               res_ff.slot      <= 4'(cell_slot[0]);
               res_ff.overwrote <= 1'b1;
               state_ff         <= ST_FINISH;
            end
            ST_ROTATE: begin
               if ((req_ff.op == OP_GET) &&
                   (CMP_W'(step_ff) == CMP_W'(req_ff.position))) begin
                  res_ff.ok        <= 1'b1;
                  res_ff.value_out <= cell_value[0];
               end
               if ((req_ff.op == OP_SEARCH) && head_match && !res_ff.ok) begin
                  res_ff.ok   <= 1'b1;
                  res_ff.slot <= 4'(cell_slot[0]);
               end
               rm_ff                <= rm_in;
               res_ff.removed_count <= 5'(rm_in);
               step_ff              <= step_ff + SLOT_W'(1);
               if (last_step) begin
                  count_ff <= count_ff - rm_in;
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_scan_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (count_ff < CNT_W'(ENTRIES)))
      else $error("free slot scan started on a full pool");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_data.op == OP_CLEAR)) |=> (count_ff == '0))
      else $error("clear left entries in the list");

   a_rm_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) |-> (rm_ff <= CNT_W'(step_ff)))
      else $error("more entries removed than visited");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && pool_hit) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("add did not grow the list");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for bounded_ordered_list_store: random and directed list operations.
// A scoreboard class keeps its own copy of the slot pool and links and predicts every response.
// Depends on bolst_pkg and the bounded_ordered_list_store top level.
`timescale 1ns / 1ps

class list_scoreboard;
   localparam int SLOTS = bolst_pkg::ENTRIES_DEFAULT;
   localparam logic [4:0] NONE = 5'(SLOTS);

   logic signed [31:0] slot_value [SLOTS];
   logic [4:0]         prev_of [SLOTS];
   logic [4:0]         next_of [SLOTS];
   bit                 is_free [SLOTS];
   logic [4:0]         oldest;
   logic [4:0]         newest;
   bolst_pkg::rsp_type expected_q[$];
   int                 error_count;

   function new();
      error_count = 0;
      empty_list();
   endfunction

   function void empty_list();
      for (int i = 0; i < SLOTS; i++) begin
         slot_value[i] = '0;
         prev_of[i] = NONE;
         next_of[i] = NONE;
         is_free[i] = 1'b1;
      end
      oldest = NONE;
      newest = NONE;
   endfunction

   function void detach(logic [4:0] s);
      logic [4:0] p;
      logic [4:0] n;
      p = prev_of[s];
      n = next_of[s];
      if (p < NONE) next_of[p] = n;
      else oldest = n;
      if (n < NONE) prev_of[n] = p;
      else newest = p;
      prev_of[s] = NONE;
      next_of[s] = NONE;
   endfunction

   function void attach(logic [4:0] s);
      prev_of[s] = newest;
      next_of[s] = NONE;
      if (newest < NONE) next_of[newest] = s;
      else oldest = s;
      newest = s;
   endfunction

   function void note_request(bolst_pkg::req_type r);
      bolst_pkg::rsp_type e;
      logic [4:0]         cur;
      logic [4:0]         nxt;
      int                 removed;
      e = '0;
      removed = 0;
      case (r.op)
         bolst_pkg::OP_ADD: begin
            cur = NONE;
            for (int i = 0; i < SLOTS && cur == NONE; i++)
               if (is_free[i]) cur = 5'(i);
            if (cur == NONE) begin
               cur = (oldest < NONE) ? oldest : 5'd0;
               detach(cur);
               e.overwrote = 1'b1;
            end
            attach(cur);
            slot_value[cur] = r.value;
            is_free[cur] = 1'b0;
            e.ok = 1'b1;
            e.slot = cur[3:0];
         end
         bolst_pkg::OP_GET: begin
            cur = oldest;
            for (int i = 0; i < SLOTS && cur < NONE && !e.ok; i++) begin
               if (i == r.position) begin
                  e.ok = 1'b1;
                  e.value_out = slot_value[cur];
               end else begin
                  cur = next_of[cur];
               end
            end
         end
         bolst_pkg::OP_SEARCH: begin
            cur = oldest;
            for (int i = 0; i < SLOTS && cur < NONE && !e.ok; i++) begin
               if (slot_value[cur] == r.value) begin
                  e.ok = 1'b1;
                  e.slot = cur[3:0];
               end else begin
                  cur = next_of[cur];
               end
            end
         end
         bolst_pkg::OP_REMOVE: begin
            cur = oldest;
            for (int i = 0; i < SLOTS && cur < NONE; i++) begin
               nxt = next_of[cur];
               if (slot_value[cur] == r.value) begin
                  detach(cur);
                  is_free[cur] = 1'b1;
                  removed++;
               end
               cur = nxt;
            end
            e.removed_count = 5'(removed);
         end
         bolst_pkg::OP_CLEAR: begin
            empty_list();
         end
         default: begin
         end
      endcase
      expected_q.push_back(e);
   endfunction

   function void check_response(bolst_pkg::rsp_type got);
      bolst_pkg::rsp_type want;
      if (expected_q.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("unexpected transfer: ok=%0b value=%0d slot=%0d removed=%0d over=%0b",
                     got.ok, got.value_out, got.slot, got.removed_count, got.overwrote);
         return;
      end
      want = expected_q.pop_front();
      if (got.ok !== want.ok || got.value_out !== want.value_out || got.slot !== want.slot ||
          got.removed_count !== want.removed_count || got.overwrote !== want.overwrote) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch: expected ok=%0b value=%0d slot=%0d removed=%0d over=%0b, %s",
                     want.ok, want.value_out, want.slot, want.removed_count, want.overwrote,
                     $sformatf("got ok=%0b value=%0d slot=%0d removed=%0d over=%0b",
                               got.ok, got.value_out, got.slot, got.removed_count,
                               got.overwrote));
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction
endclass

module tb;
   import bolst_pkg::*;

   localparam int RUN_LIMIT   = 1000000;
   localparam int HOLD_CYCLES = 300;
   localparam int ITEM_COUNT  = 1750;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int cycle_count = 0;

   list_scoreboard sb = new();

   bounded_ordered_list_store DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [31:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return 32'($signed($urandom_range(0, 7)) - 3);
      if (roll == 6) return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
      return $urandom;
   endfunction

   function automatic req_type make_item(logic [2:0] op, logic signed [31:0] value,
                                         logic [3:0] position);
      req_type r;
      r.op = op;
      r.value = value;
      r.position = position;
      return r;
   endfunction

   function automatic req_type random_item();
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      if (roll < 42) r.op = OP_ADD;
      else if (roll < 62) r.op = OP_GET;
      else if (roll < 76) r.op = OP_SEARCH;
      else if (roll < 91) r.op = OP_REMOVE;
      else if (roll < 92) r.op = OP_CLEAR;
      else r.op = 3'($urandom_range(5, 7));
      r.value = pick_value();
      r.position = 4'($urandom_range(0, 15));
      return r;
   endfunction

   task automatic send(input req_type item);
      int gap;
      gap = (quiet || hold_request) ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic run_directed();
      send(make_item(OP_GET, 32'sd0, 4'd0));
      send(make_item(OP_SEARCH, 32'sd5, 4'd0));
      send(make_item(OP_REMOVE, 32'sd5, 4'd0));
      send(make_item(OP_ADD, 32'sd7, 4'd0));
      send(make_item(OP_REMOVE, 32'sd7, 4'd0));
      send(make_item(OP_ADD, 32'h80000000, 4'd0));
      send(make_item(OP_ADD, 32'h7fffffff, 4'd0));
      send(make_item(OP_ADD, -32'sd1, 4'd0));
      send(make_item(OP_ADD, -32'sd1, 4'd0));
      // fill the pool, then overwrite the oldest
      repeat (13) send(make_item(OP_ADD, 32'($urandom), 4'd0));
      send(make_item(OP_GET, 32'sd0, 4'd15));
      send(make_item(OP_GET, 32'sd0, 4'd0));
      send(make_item(OP_SEARCH, 32'h7fffffff, 4'd0));
      send(make_item(OP_SEARCH, 32'sd123, 4'd0));
      send(make_item(OP_REMOVE, -32'sd1, 4'd0));
      send(make_item(OP_GET, 32'sd0, 4'd15));
      send(make_item(OP_REMOVE, 32'sd99, 4'd0));
      send(make_item(3'd7, 32'hffffffff, 4'd15));
      send(make_item(OP_CLEAR, 32'sd0, 4'd0));
   endtask

   initial begin : receiver
      int span;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            for (span = 0; span < HOLD_CYCLES; span++) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            span = pick_gap();
            if (span == 0) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               repeat (span) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      req_type item;
      int      counted;
      int      n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      counted = 0;
      n = 0;
      while (counted < ITEM_COUNT) begin
         quiet = ((n / 200) % 4) == 2;
         if (n == 700) hold_request = 1'b1;
         item = random_item();
         send(item);
         counted++;
         n++;
      end
      req_valid <= 1'b0;
      quiet = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
